@@ sv/psr_pkg.sv @@
// psr_pkg: shared constants and types for the pi speed regulator
// no dependencies; imported by psr_mul and pi_speed_regulator

package psr_pkg;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_SPEED_SCALE   = 3'd0,
      REG_SAMPLE_PERIOD = 3'd1,
      REG_PROP_GAIN     = 3'd2,
      REG_INT_GAIN      = 3'd3,
      REG_INT_LIMIT     = 3'd4
   } csr_idx_type;

   localparam logic [15:0] SPEED_SCALE_RST   = 16'd161;
   localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd655;
   localparam logic [14:0] PROP_GAIN_RST     = 15'd0;
   localparam logic [14:0] INT_GAIN_RST      = 15'd0;
   localparam logic [14:0] INT_LIMIT_RST     = 15'd0;

   // shared multiplier: wide signed operand times narrow signed operand
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // drive shaping in Q.8
   localparam int DRIVE_W = 50;
   localparam int SAT_W   = 17;
   localparam logic signed [DRIVE_W-1:0] DB_THRESH = DRIVE_W'(5 * 256);
   localparam logic signed [DRIVE_W-1:0] DB_COMP   = DRIVE_W'(35 * 256);
   localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = DRIVE_W'(255 * 256);

endpackage

@@ sv/psr_mul.sv @@
// psr_mul: shared signed multiplier with registered product
// depends on psr_pkg for default operand widths

module psr_mul import psr_pkg::*; #(
   parameter int A_W = MUL_A_W,
   parameter int B_W = MUL_B_W
) (
   input  logic                     clock,
   input  logic signed [A_W-1:0]    mul_a,
   input  logic signed [B_W-1:0]    mul_b,
   output logic signed [A_W+B_W-1:0] prod_ff
);

   logic signed [A_W+B_W-1:0] prod_in;

   assign prod_in = (A_W+B_W)'(mul_a) * (A_W+B_W)'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

@@ sv/pi_speed_regulator.sv @@
// pi_speed_regulator: pi speed loop with clamped integrator and drive shaping
// a request transfer in S_IDLE is followed by 9 sequencer steps, S_SPEED to S_OUT;
// no new request is taken until S_OUT hands its result on, since the four products
// of a tick share one registered multiplier under the sequencer
// the next request is taken while a finished result still waits for transfer
// synchronous active-high reset: registers to reset values, integrator zero

module pi_speed_regulator import psr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [15:0]    req_target_speed,
   input  logic        [15:0]    req_count_now,
   input  logic        [15:0]    req_count_before,
   input  logic                  req_clear_integral,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_forward,
   output logic        [7:0]     rsp_duty,
   output logic signed [31:0]    rsp_measured_speed,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   typedef enum logic [3:0] {
      S_IDLE, S_SPEED, S_ERR, S_INC, S_INTEG, S_CLAMP, S_IMUL, S_DRIVE, S_SHAPE, S_OUT
   } state_type;

   localparam int INT_W = 24;
   localparam int ERR_W = 33;
   localparam int INC_W = 34;
   localparam int SUM_W = 35;
   localparam int LIM_W = 25;

   // configuration registers
   logic [15:0] speed_scale_ff;
   logic [15:0] sample_period_ff;
   logic [14:0] prop_gain_ff;
   logic [14:0] int_gain_ff;
   logic [14:0] int_limit_ff;

   csr_idx_type csr_idx;
   logic        csr_wr;

   // sequencer and datapath
   state_type state_ff, state_in;
   logic signed [15:0]        target_ff, dp_in, dp_ff;
   logic                      clear_ff;
   logic signed [31:0]        speed_ff;
   logic signed [ERR_W-1:0]   error_ff, error_in;
   logic signed [INC_W-1:0]   inc_ff, inc_in;
   logic signed [INT_W-1:0]   integ_ff, integ_in, integ_base;
   logic signed [DRIVE_W-1:0] drive_ff, drive_in, drive_db;
   logic signed [SAT_W-1:0]   sat_ff, sat_in;
   logic signed [SUM_W-1:0]   integ_sum, lim_pos, lim_neg;
   logic signed [LIM_W-1:0]   lim_q;
   logic signed [MUL_P_W-1:0] inc_bias;
   logic [SAT_W-1:0]          sat_mag;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;

   logic                      rsp_valid_ff, rsp_forward_ff, rsp_load;
   logic [7:0]                rsp_duty_ff;
   logic signed [31:0]        rsp_speed_ff;

   // ---------------- configuration port ----------------
   assign pready  = 1'b1;
   assign csr_idx = csr_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_wr  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_scale_ff   <= SPEED_SCALE_RST;
         sample_period_ff <= SAMPLE_PERIOD_RST;
         prop_gain_ff     <= PROP_GAIN_RST;
         int_gain_ff      <= INT_GAIN_RST;
         int_limit_ff     <= INT_LIMIT_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_SPEED_SCALE:   speed_scale_ff   <= pwdata[15:0];
            REG_SAMPLE_PERIOD: sample_period_ff <= pwdata[15:0];
            REG_PROP_GAIN:     prop_gain_ff     <= pwdata[14:0];
            REG_INT_GAIN:      int_gain_ff      <= pwdata[14:0];
            REG_INT_LIMIT:     int_limit_ff     <= pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_SPEED_SCALE:   prdata = {16'd0, speed_scale_ff};
         REG_SAMPLE_PERIOD: prdata = {16'd0, sample_period_ff};
         REG_PROP_GAIN:     prdata = {17'd0, prop_gain_ff};
         REG_INT_GAIN:      prdata = {17'd0, int_gain_ff};
         REG_INT_LIMIT:     prdata = {17'd0, int_limit_ff};
         default:           prdata = '0;
      endcase
   end

   // ---------------- shared multiplier ----------------
   always_comb begin
      unique case (state_ff)
         S_SPEED: begin
            mul_a = MUL_A_W'(dp_ff);
            mul_b = $signed({1'b0, speed_scale_ff});
         end
         S_INC: begin
            mul_a = MUL_A_W'(error_ff);
            mul_b = $signed({1'b0, sample_period_ff});
         end
         S_INTEG: begin
            mul_a = MUL_A_W'(error_ff);
            mul_b = $signed({2'b00, prop_gain_ff});
         end
         S_IMUL: begin
            mul_a = MUL_A_W'(integ_ff);
            mul_b = $signed({2'b00, int_gain_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   psr_mul #(
      .A_W (MUL_A_W),
      .B_W (MUL_B_W)
   ) u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (mul_p)
   );

   // ---------------- datapath next values ----------------
   assign dp_in    = $signed(req_count_now - req_count_before);
   assign error_in = ERR_W'(target_ff) - ERR_W'($signed(mul_p[31:0]));

   // divide by 2^16 rounding toward zero
   assign inc_bias = mul_p + $signed({{(MUL_P_W-16){1'b0}}, {16{mul_p[MUL_P_W-1]}}});
   assign inc_in   = inc_bias[INC_W+15:16];

   assign lim_q      = $signed({2'b00, int_limit_ff, 8'd0});
   assign lim_pos    = SUM_W'(lim_q);
   assign lim_neg    = -lim_pos;
   assign integ_base = clear_ff ? '0 : integ_ff;
   assign integ_sum  = SUM_W'(integ_base) + SUM_W'(inc_ff);

   always_comb begin
      if (integ_sum > lim_pos) begin
         integ_in = lim_pos[INT_W-1:0];
      end else if (integ_sum < lim_neg) begin
         integ_in = lim_neg[INT_W-1:0];
      end else begin
         integ_in = integ_sum[INT_W-1:0];
      end
   end

   assign drive_in = drive_ff + mul_p[DRIVE_W-1:0];

   // deadband compensation folded with saturation
   always_comb begin
      if (drive_ff > DB_THRESH) begin
         drive_db = (drive_ff > DRIVE_MAX - DB_COMP) ? DRIVE_MAX : drive_ff + DB_COMP;
      end else if (drive_ff < -DB_THRESH) begin
         drive_db = (drive_ff < DB_COMP - DRIVE_MAX) ? -DRIVE_MAX : drive_ff - DB_COMP;
      end else begin
         drive_db = drive_ff;
      end
   end
   assign sat_in  = drive_db[SAT_W-1:0];
   assign sat_mag = sat_ff[SAT_W-1] ? SAT_W'(-sat_ff) : SAT_W'(sat_ff);

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            target_ff <= req_target_speed;
            dp_ff     <= dp_in;
            clear_ff  <= req_clear_integral;
         end
         S_ERR: begin
            speed_ff <= mul_p[31:0];
            error_ff <= error_in;
         end
         S_INTEG: inc_ff   <= inc_in;
         S_CLAMP: drive_ff <= mul_p[DRIVE_W-1:0];
         S_DRIVE: drive_ff <= drive_in;
         S_SHAPE: sat_ff   <= sat_in;
         default: ;
      endcase
   end

   // ---------------- sequencer ----------------
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      unique case (state_ff)
         S_IDLE:  state_in = req_valid ? S_SPEED : S_IDLE;
         S_SPEED: state_in = S_ERR;
         S_ERR:   state_in = S_INC;
         S_INC:   state_in = S_INTEG;
         S_INTEG: state_in = S_CLAMP;
         S_CLAMP: state_in = S_IMUL;
         S_IMUL:  state_in = S_DRIVE;
         S_DRIVE: state_in = S_SHAPE;
         S_SHAPE: state_in = S_OUT;
         S_OUT:   state_in = rsp_load ? S_IDLE : S_OUT;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLAMP) begin
            integ_ff <= integ_in;
         end
         if (rsp_load) begin
            rsp_valid_ff   <= 1'b1;
            // truncated drive is non-negative unless at or below -1.0
            rsp_forward_ff <= (sat_ff > -SAT_W'(256));
            rsp_duty_ff    <= sat_mag[15:8];
            rsp_speed_ff   <= speed_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_forward        = rsp_forward_ff;
   assign rsp_duty           = rsp_duty_ff;
   assign rsp_measured_speed = rsp_speed_ff;

   // ---------------- assertions ----------------
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a tick is in progress");

   a_integ_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IMUL) |-> (LIM_W'(integ_ff) <= lim_q && LIM_W'(integ_ff) >= -lim_q))
      else $error("integrator outside its clamp");

   a_drive_saturated: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> (DRIVE_W'(sat_ff) <= DRIVE_MAX && DRIVE_W'(sat_ff) >= -DRIVE_MAX))
      else $error("shaped drive beyond saturation");

   a_reverse_has_duty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_forward) |-> (rsp_duty != 8'd0))
      else $error("reverse direction with zero duty");

endmodule
